// ----- rtl/core/postfix_stack_evaluator_macros.svh -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_macros
// Assertion macros used by the postfix evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define PSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Types and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic MODE_OPERAND  = 1'b0;
    localparam logic MODE_OPERATOR = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

endpackage

// ----- rtl/core/pse_div.sv -----
// ----------------------------------------------------------------------------
// pse_div
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pse_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pse_pkg::word_t dividend,
    input  pse_pkg::word_t divisor,
    output logic          done,
    output pse_pkg::word_t quotient
);
    import pse_pkg::*;

    localparam int CW = $clog2(WORD_W) + 1;

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic              neg_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] dvs_reg;

    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;

    assign mag_a = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
    assign mag_b = divisor[WORD_W-1]  ? (WORD_W'(0) - divisor)  : divisor;
    assign trial = {rem_reg, quo_reg[WORD_W-1]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WORD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= mag_a;
            dvs_reg <= mag_b;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_reg <= trial[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (WORD_W'(0) - quo_reg) : quo_reg;

endmodule

// ----- rtl/core/postfix_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// An operand token is taken in S_IDLE. An add/sub/mul token passes S_OPB, S_OPA
// and S_WB (two stack reads, execute, write-back). A divide token also waits in
// S_DIV for the bit-serial divider. A last token adds S_POP and S_EMIT for the final pop.
// Reset clears depth, sticky status and handshake state; stack RAM is not cleared.
// ----------------------------------------------------------------------------
`include "postfix_stack_evaluator_macros.svh"

module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           token_valid,
    output logic           token_stall,
    input  logic           mode,
    input  logic [1:0]     op,
    input  pse_pkg::word_t value,
    input  logic           last,
    output logic           result_valid,
    input  logic           result_stall,
    output pse_pkg::word_t result,
    output logic [1:0]     status
);
    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPB,
        S_OPA,
        S_DIV,
        S_WB,
        S_POP,
        S_EMIT
    } state_t;

    state_t  state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    status_t err_reg, err_next;
    op_t     op_reg, op_next;
    logic    last_reg, last_next;
    word_t   b_reg, b_next;
    word_t   c_reg, c_next;
    logic    result_valid_reg, result_valid_next;
    word_t   result_reg, result_next;
    status_t status_reg, status_next;

    word_t   stack_mem [STACK_DEPTH];
    word_t   rd_data_reg;
    logic    mem_re;
    logic    mem_we;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;
    word_t   mem_wdata;

    logic    has_one;
    logic    has_two;
    logic    full;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] second_addr;
    word_t   a_val;
    word_t   mul_lo;
    logic    out_free;

    logic    div_start;
    logic    div_done;
    word_t   div_quo;

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_val),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign has_one     = (depth_reg != '0);
    assign has_two     = (depth_reg >= DW'(2));
    assign full        = (depth_reg == DW'(STACK_DEPTH));
    assign depth_m1    = depth_reg - DW'(1);
    assign depth_m2    = depth_reg - DW'(2);
    assign top_addr    = depth_m1[AW-1:0];
    assign second_addr = depth_m2[AW-1:0];
    assign a_val       = has_two ? rd_data_reg : '0;
    assign mul_lo      = a_val * b_reg;
    assign out_free    = !result_valid_reg || !result_stall;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        depth_next        = depth_reg;
        err_next          = err_reg;
        op_next           = op_reg;
        last_next         = last_reg;
        b_next            = b_reg;
        c_next            = c_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        status_next       = status_reg;
        mem_re            = 1'b0;
        mem_raddr         = top_addr;
        mem_we            = 1'b0;
        mem_waddr         = depth_reg[AW-1:0];
        mem_wdata         = value;
        div_start         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (token_valid)
                begin
                    last_next = last;
                    if (mode == MODE_OPERATOR)
                    begin
                        op_next    = op_t'(op);
                        mem_re     = has_one;
                        mem_raddr  = top_addr;
                        state_next = S_OPB;
                    end
                    else
                    begin
                        if (!full)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = depth_reg[AW-1:0];
                            mem_wdata  = value;
                            depth_next = depth_reg + DW'(1);
                        end
                        else if (err_reg == ST_OK)
                        begin
                            err_next = ST_OVER;
                        end
                        state_next = last ? S_POP : S_IDLE;
                    end
                end
            end
            S_OPB:
            begin
                b_next     = has_one ? rd_data_reg : '0;
                mem_re     = has_two;
                mem_raddr  = second_addr;
                state_next = S_OPA;
            end
            S_OPA:
            begin
                if (err_reg == ST_OK)
                begin
                    if (!has_two)
                    begin
                        err_next = ST_UNDER;
                    end
                    else if (op_reg == OP_DIV && b_reg == '0)
                    begin
                        err_next = ST_DIVZ;
                    end
                end
                state_next = S_WB;
                case (op_reg)
                    OP_ADD: c_next = a_val + b_reg;
                    OP_SUB: c_next = a_val - b_reg;
                    OP_MUL: c_next = mul_lo;
                    OP_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            c_next = '0;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default: c_next = '0;
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    c_next     = div_quo;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                mem_we     = 1'b1;
                mem_waddr  = has_two ? second_addr : '0;
                mem_wdata  = c_reg;
                depth_next = has_two ? depth_m1 : DW'(1);
                state_next = last_reg ? S_POP : S_IDLE;
            end
            S_POP:
            begin
                mem_re     = has_one;
                mem_raddr  = top_addr;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next       = has_one ? rd_data_reg : '0;
                    status_next       = (err_reg == ST_OK && !has_one) ? ST_UNDER : err_reg;
                    depth_next        = '0;
                    err_next          = ST_OK;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            depth_reg        <= '0;
            err_reg          <= ST_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            depth_reg        <= depth_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        last_reg   <= last_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign token_stall  = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign status       = status_reg;

    `PSE_ASSERT_IMP(a_depth_bound, 1'b1, depth_reg <= DW'(STACK_DEPTH), "stack depth past limit")
    `PSE_ASSERT_IMP(a_div_done_state, div_done, state_reg == S_DIV, "divider done outside wait")
    `PSE_ASSERT_NXT(a_emit_clears, state_reg == S_EMIT && out_free, depth_reg == '0 && err_reg == ST_OK, "stack not cleared after result")
    `PSE_ASSERT_IMP(a_result_from_emit, $rose(result_valid_reg), $past(state_reg) == S_EMIT, "result transaction without final pop")

endmodule

// ----- test/postfix_stack_evaluator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_test
// Self-checking bench for the postfix stack evaluator. A directed set of
// expressions covers operand extremes, every operator, divide by zero and underflow.
// Random expressions follow: mostly well formed, some deep, some broken
// (underflow, overflow, leftover operands, noise). A local stack model
// predicts result and status for each accepted last token. The monitor
// compares them in order. Both handshakes see random idle bursts.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_test;

    import pse_pkg::*;

    localparam int EVAL_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 1600;
    localparam int TAIL_ITEMS   = 150;
    localparam int PAUSE_EVERY  = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        bit      pause;
        logic    mode;
        op_t     op;
        word_t   value;
        logic    last;
    } token_t;

    typedef struct {
        word_t   result;
        status_t status;
    } outcome_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       token_valid  = 1'b0;
    logic       token_stall;
    logic       mode         = MODE_OPERAND;
    logic [1:0] op           = OP_ADD;
    word_t      value        = '0;
    logic       last         = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    word_t      result;
    logic [1:0] status;

    token_t      token_feed[$];
    outcome_t    pending_outcomes[$];
    int unsigned token_total     = 0;
    int unsigned accepted_tokens = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;
    int unsigned gap_left        = 0;
    int unsigned stall_left      = 0;

    word_t       eval_stack[EVAL_DEPTH];
    int unsigned eval_depth  = 0;
    status_t     eval_status = ST_OK;

    postfix_stack_evaluator #(
        .STACK_DEPTH (EVAL_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .mode         (mode),
        .op           (op),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // stack model
    // ------------------------------------------------------------------
    function automatic void note_fault(status_t code);
        if (eval_status == ST_OK)
            eval_status = code;
    endfunction

    function automatic void push_eval(word_t v);
        if (eval_depth >= EVAL_DEPTH)
        begin
            note_fault(ST_OVER);
        end
        else
        begin
            eval_stack[eval_depth] = v;
            eval_depth++;
        end
    endfunction

    function automatic word_t pop_eval();
        if (eval_depth == 0)
        begin
            note_fault(ST_UNDER);
            return '0;
        end
        eval_depth--;
        return eval_stack[eval_depth];
    endfunction

    function automatic word_t quotient_toward_zero(word_t dividend, word_t divisor);
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] quo;
        mag_n = dividend[31] ? (32'd0 - dividend) : dividend;
        mag_d = divisor[31] ? (32'd0 - divisor) : divisor;
        quo   = mag_n / mag_d;
        return (dividend[31] != divisor[31]) ? word_t'(32'd0 - quo) : word_t'(quo);
    endfunction

    function automatic void predict_token(logic m, logic [1:0] o, word_t v, logic l);
        word_t    lhs;
        word_t    rhs;
        word_t    res;
        outcome_t due;
        if (m == MODE_OPERAND)
        begin
            push_eval(v);
        end
        else
        begin
            rhs = pop_eval();
            lhs = pop_eval();
            case (op_t'(o))
                OP_ADD: res = lhs + rhs;
                OP_SUB: res = lhs - rhs;
                OP_MUL: res = lhs * rhs;
                default:
                begin
                    if (rhs == 0)
                    begin
                        note_fault(ST_DIVZ);
                        res = '0;
                    end
                    else
                    begin
                        res = quotient_toward_zero(lhs, rhs);
                    end
                end
            endcase
            push_eval(res);
        end
        if (l)
        begin
            due.result = pop_eval();
            due.status = eval_status;
            pending_outcomes.push_back(due);
            eval_depth  = 0;
            eval_status = ST_OK;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic void add_token(logic m, op_t o, word_t v, logic l);
        token_t tok;
        tok.pause = 1'b0;
        tok.mode  = m;
        tok.op    = o;
        tok.value = v;
        tok.last  = l;
        token_feed.push_back(tok);
        token_total++;
    endfunction

    function automatic void add_pause();
        token_t tok;
        tok.pause = 1'b1;
        tok.mode  = MODE_OPERAND;
        tok.op    = OP_ADD;
        tok.value = '0;
        tok.last  = 1'b0;
        token_feed.push_back(tok);
    endfunction

    function automatic op_t random_op();
        return op_t'($urandom_range(0, 3));
    endfunction

    function automatic word_t random_word();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return -32'sd1;
                    3: return 32'sd1;
                    default: return 32'sd0;
                endcase
            end
            1, 2, 3: return word_t'(int'($urandom_range(0, 40)) - 20);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic void add_operand(word_t v, logic l);
        add_token(MODE_OPERAND, random_op(), v, l);
    endfunction

    function automatic void add_operator(op_t o, logic l);
        add_token(MODE_OPERATOR, o, word_t'($urandom), l);
    endfunction

    // well-formed expression, depth capped at max_depth
    function automatic void add_expression(int unsigned len, int unsigned max_depth,
                                           int unsigned push_pct);
        int unsigned depth = 0;
        int unsigned count = 0;
        bit          operator_turn;
        bit          done = 1'b0;
        while (!done)
        begin
            if (depth < 2)
                operator_turn = 1'b0;
            else if (depth >= max_depth || count >= len)
                operator_turn = 1'b1;
            else
                operator_turn = ($urandom_range(0, 99) >= push_pct);
            if (operator_turn)
                depth--;
            else
                depth++;
            count++;
            done = (count >= len) && (depth == 1);
            if (operator_turn)
                add_operator(random_op(), done);
            else
                add_operand(random_word(), done);
        end
    endfunction

    function automatic void add_broken_expression();
        int unsigned n;
        case ($urandom_range(0, 3))
            0:
            begin
                n = $urandom_range(1, 4);
                for (int i = 1; i <= n; i++)
                    add_operator(random_op(), i == n);
            end
            1:
            begin
                n = $urandom_range(EVAL_DEPTH + 1, EVAL_DEPTH + 4);
                for (int i = 0; i < n; i++)
                    add_operand(random_word(), 1'b0);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    add_operator(random_op(), 1'b0);
                add_operator(random_op(), 1'b1);
            end
            2:
            begin
                n = $urandom_range(2, 5);
                for (int i = 1; i <= n; i++)
                    add_operand(random_word(), i == n);
            end
            default:
            begin
                n = $urandom_range(1, 8);
                for (int i = 1; i <= n; i++)
                    add_token(logic'($urandom_range(0, 1)), random_op(), word_t'($urandom),
                              i == n);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // token driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_tokens
        token_t tok;
        if (!rst_n)
        begin
            token_valid <= 1'b0;
            mode        <= MODE_OPERAND;
            op          <= OP_ADD;
            value       <= '0;
            last        <= 1'b0;
            gap_left     = 0;
        end
        else
        begin
            if (token_valid && !token_stall)
            begin
                predict_token(mode, op, value, last);
                accepted_tokens++;
            end
            if (!token_valid || !token_stall)
            begin
                if (token_feed.size() > 0 && token_feed[0].pause)
                begin
                    token_valid <= 1'b0;
                    if (pending_outcomes.size() == 0)
                        void'(token_feed.pop_front());
                end
                else if (gap_left > 0)
                begin
                    token_valid <= 1'b0;
                    gap_left--;
                end
                else if (token_feed.size() > 0)
                begin
                    tok          = token_feed.pop_front();
                    token_valid <= 1'b1;
                    mode        <= tok.mode;
                    op          <= tok.op;
                    value       <= tok.value;
                    last        <= tok.last;
                    if (token_feed.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 16);
                end
                else
                begin
                    token_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        outcome_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left    = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("unexpected transaction: result %0d, status code %0d",
                           result, status);
                    fail_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (result !== want.result)
                    begin
                        $error("result mismatch: expected %0d, actual %0d",
                               want.result, result);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else if (token_feed.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
            begin
                result_stall <= 1'b1;
                stall_left    = $urandom_range(0, 15);
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : run_sequence
        int unsigned next_pause;
        int unsigned pick;

        // max + 1 wraps to min
        add_operand(32'sh7fffffff, 1'b0);
        add_operand(32'sd1, 1'b0);
        add_operator(OP_ADD, 1'b1);
        // min / -1 wraps to min
        add_operand(32'sh80000000, 1'b0);
        add_operand(-32'sd1, 1'b0);
        add_operator(OP_DIV, 1'b1);
        // divide by zero
        add_operand(32'sd7, 1'b0);
        add_operand(32'sd0, 1'b0);
        add_operator(OP_DIV, 1'b1);
        // operator on empty stack
        add_operator(OP_SUB, 1'b1);
        // truncation toward zero, then multiply
        add_operand(-32'sd7, 1'b0);
        add_operand(32'sd2, 1'b0);
        add_operator(OP_DIV, 1'b0);
        add_operand(32'sh80000000, 1'b0);
        add_operator(OP_MUL, 1'b1);
        // single operand under an operator
        add_operand(32'sd5, 1'b0);
        add_operator(OP_SUB, 1'b1);
        // sticky: divide by zero kept over a later underflow
        add_operand(32'sd1, 1'b0);
        add_operand(32'sd0, 1'b0);
        add_operator(OP_DIV, 1'b0);
        add_operator(OP_SUB, 1'b1);
        add_pause();

        next_pause = token_total + PAUSE_EVERY;
        while (token_total < RANDOM_ITEMS + 21)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                add_expression($urandom_range(1, 12), $urandom_range(2, 8), 55);
            else if (pick < 78)
                add_expression($urandom_range(EVAL_DEPTH, 2 * EVAL_DEPTH + 6), EVAL_DEPTH, 90);
            else
                add_broken_expression();
            if (token_total >= next_pause)
            begin
                add_pause();
                next_pause = token_total + PAUSE_EVERY;
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_tokens < token_total || pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_outcomes.size() != 0)
        begin
            $error("%0d expected transactions never arrived", pending_outcomes.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pse_pkg.sv
rtl/core/pse_div.sv
rtl/core/postfix_stack_evaluator.sv
test/postfix_stack_evaluator_test.sv
